// File: src/flfr_pkg.sv
// shared types and constants for the fixed length frame receiver
package flfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 2'd3;

    // check byte kinds
    localparam logic CHECK_SUM = 1'b0;
    localparam logic CHECK_XOR = 1'b1;

    // result status codes
    localparam logic STATUS_PAYLOAD = 1'b0;
    localparam logic STATUS_CHECK_ERROR = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] own_address;
        logic [BYTE_W-1:0] bcast_addr;
        logic              check_mode;
    } t_cfg;

endpackage

// File: src/fixed_length_frame_receiver.sv
// top level of the fixed length frame receiver: config registers, frame store, sequencer
//
// usage
// - slave stream carries received serial bytes, one request per byte; all
//   bytes are taken while hunting for the start byte, which is not stored
// - after the start byte, FRAME_LEN bytes form a frame: address, data, check
// - master stream carries results: tdata payload byte, tuser status
//   (0 payload, 1 check byte mismatch), tlast on the last result of a frame
// - frames whose address is neither own nor broadcast give no result
// - a bad check byte gives one result, valid from the cycle after the check byte is taken
// - a good frame gives bytes PAYLOAD_START .. FRAME_LEN-2, each read from ram
//   (state S_RD) and then loaded into the output register (state S_DATA);
//   no byte is taken during read-out
// - one byte per cycle while collecting, save for the check byte held off as below
// - a stalled master holds the output register; the check byte is held off
//   and read-out pauses until the pending result is taken
// - reset (synchronous, active low) returns to hunting, drops any result
//   and loads the register defaults; the frame store is not cleared
// - configuration writes are registered, to be done while idle
module fixed_length_frame_receiver #(
    parameter int FRAME_LEN = 16,
    parameter int PAYLOAD_START = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [flfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [flfr_pkg::BYTE_W-1:0]      i_cfg_data,
    // received bytes
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [flfr_pkg::BYTE_W-1:0]      i_s_tdata,   // [7:0] rx_byte
    // results
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [flfr_pkg::BYTE_W-1:0]      o_m_tdata,   // [7:0] payload_byte
    output logic                             o_m_tuser,   // [0] frame_status
    output logic                             o_m_tlast
);

    localparam int IDX_W = $clog2(FRAME_LEN);

    flfr_pkg::t_cfg              r_cfg;

    logic                        w_ram_we;
    logic [IDX_W-1:0]            w_ram_waddr;
    logic [flfr_pkg::BYTE_W-1:0] w_ram_wdata;
    logic [IDX_W-1:0]            w_ram_raddr;
    logic [flfr_pkg::BYTE_W-1:0] w_ram_rdata;

    // configuration registers, upper data bits dropped for the one bit mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= 8'd0;
            r_cfg.own_address <= 8'd0;
            r_cfg.bcast_addr  <= 8'd255;
            r_cfg.check_mode  <= flfr_pkg::CHECK_SUM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                flfr_pkg::CFG_START_BYTE:  r_cfg.start_byte <= i_cfg_data;
                flfr_pkg::CFG_OWN_ADDRESS: r_cfg.own_address <= i_cfg_data;
                flfr_pkg::CFG_BCAST_ADDR:  r_cfg.bcast_addr <= i_cfg_data;
                flfr_pkg::CFG_CHECK_MODE:  r_cfg.check_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // frame store, one entry per frame byte
    flfr_ram #(
        .WIDTH (flfr_pkg::BYTE_W),
        .DEPTH (FRAME_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    flfr_frame_ctl #(
        .FRAME_LEN     (FRAME_LEN),
        .PAYLOAD_START (PAYLOAD_START)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule

// File: src/flfr_ram.sv
// generic single write port ram with registered read
module flfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/flfr_frame_ctl.sv
// frame sequencer: start hunt, byte collection, check, payload read-out
module flfr_frame_ctl #(
    parameter int FRAME_LEN = 16,
    parameter int PAYLOAD_START = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  flfr_pkg::t_cfg                  i_cfg,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [flfr_pkg::BYTE_W-1:0]     i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [flfr_pkg::BYTE_W-1:0]     o_m_tdata,
    output logic                            o_m_tuser,
    output logic                            o_m_tlast,
    output logic                            o_ram_we,
    output logic [$clog2(FRAME_LEN)-1:0]    o_ram_waddr,
    output logic [flfr_pkg::BYTE_W-1:0]     o_ram_wdata,
    output logic [$clog2(FRAME_LEN)-1:0]    o_ram_raddr,
    input  logic [flfr_pkg::BYTE_W-1:0]     i_ram_rdata
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_PAYLOAD_IDX = IDX_W'(FRAME_LEN - 2);
    localparam logic [IDX_W-1:0] FIRST_PAYLOAD_IDX = IDX_W'(PAYLOAD_START);
    localparam bit NO_PAYLOAD = (PAYLOAD_START > FRAME_LEN - 2);

    typedef enum logic [1:0] {S_HUNT, S_COLLECT, S_RD, S_DATA} t_state;

    t_state                      r_state;
    logic [IDX_W-1:0]            r_cnt;
    logic [flfr_pkg::BYTE_W-1:0] r_chk;
    logic [flfr_pkg::BYTE_W-1:0] r_addr;
    logic                        r_out_valid;
    logic [flfr_pkg::BYTE_W-1:0] r_out_data;
    logic                        r_out_status;
    logic                        r_out_last;

    logic                        w_slot_free;
    logic                        w_last;
    logic                        w_accept;
    logic                        w_match;
    logic                        w_load;
    logic [flfr_pkg::BYTE_W-1:0] n_chk;

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_last      = (r_cnt == LAST_IDX);
    assign o_s_tready  = (r_state == S_HUNT) ||
                         ((r_state == S_COLLECT) && (!w_last || w_slot_free));
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_match     = (r_addr == i_cfg.own_address) ||
                         (r_addr == i_cfg.bcast_addr);
    assign n_chk       = (i_cfg.check_mode == flfr_pkg::CHECK_XOR) ?
                         (r_chk ^ i_s_tdata) : (r_chk + i_s_tdata);
    // output register is loaded this cycle (error report or payload byte)
    assign w_load      = ((r_state == S_COLLECT) && w_accept && w_last && w_match &&
                          (i_s_tdata != r_chk)) ||
                         ((r_state == S_DATA) && w_slot_free);

    // the byte counter doubles as the read-out index
    assign o_ram_we    = w_accept && (r_state == S_COLLECT);
    assign o_ram_waddr = r_cnt;
    assign o_ram_wdata = i_s_tdata;
    assign o_ram_raddr = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT;
            r_cnt       <= '0;
            r_chk       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_HUNT: begin
                    if (w_accept && (i_s_tdata == i_cfg.start_byte)) begin
                        r_state <= S_COLLECT;
                        r_cnt   <= '0;
                        r_chk   <= '0;
                    end
                end
                S_COLLECT: begin
                    if (w_accept) begin
                        if (r_cnt == '0) begin
                            r_addr <= i_s_tdata;
                        end
                        if (!w_last) begin
                            r_chk <= n_chk;
                            r_cnt <= r_cnt + IDX_W'(1);
                        end else begin
                            r_chk <= '0;
                            if (w_match && (i_s_tdata != r_chk)) begin
                                r_out_valid  <= 1'b1;
                                r_out_data   <= '0;
                                r_out_status <= flfr_pkg::STATUS_CHECK_ERROR;
                                r_out_last   <= 1'b1;
                                r_cnt        <= '0;
                                r_state      <= S_HUNT;
                            end else if (w_match && !NO_PAYLOAD) begin
                                r_cnt   <= FIRST_PAYLOAD_IDX;
                                r_state <= S_RD;
                            end else begin
                                r_cnt   <= '0;
                                r_state <= S_HUNT;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    // read address held, so the ram data stays valid while stalled
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= i_ram_rdata;
                        r_out_status <= flfr_pkg::STATUS_PAYLOAD;
                        r_out_last   <= (r_cnt == LAST_PAYLOAD_IDX);
                        if (r_cnt == LAST_PAYLOAD_IDX) begin
                            r_cnt   <= '0;
                            r_state <= S_HUNT;
                        end else begin
                            r_cnt   <= r_cnt + IDX_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_HUNT;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

// File: src/flfr_checker.sv
// port level checks for the fixed length frame receiver, with bind
module flfr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [flfr_pkg::BYTE_W-1:0] o_m_tdata,
    input logic                        o_m_tuser,
    input logic                        o_m_tlast
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // a check error result is a zero item closing its frame
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == flfr_pkg::STATUS_CHECK_ERROR)) |->
        (o_m_tlast && (o_m_tdata == '0)))
        else $error("malformed check error result");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind fixed_length_frame_receiver flfr_checker u_flfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// File: test/flfr_result_checker.sv
`timescale 1ns / 1ps
// result checker for the frame receiver: tracks registers and frame state, compares result stream
module flfr_result_checker #(
    parameter int FRAME_LEN = 16,
    parameter int PAYLOAD_START = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [flfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [flfr_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [flfr_pkg::BYTE_W-1:0]    i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [flfr_pkg::BYTE_W-1:0]    i_m_tdata,
    input  logic                           i_m_tuser,
    input  logic                           i_m_tlast,
    output int                             o_mismatches,
    output int                             o_pending
);

    typedef struct packed {
        logic [flfr_pkg::BYTE_W-1:0] payload;
        logic                        status;
        logic                        last;
    } t_frame_result;

    flfr_pkg::t_cfg              regs;
    logic                        in_frame;
    int                          frame_pos;
    logic [flfr_pkg::BYTE_W-1:0] check_acc;
    logic [flfr_pkg::BYTE_W-1:0] frame_bytes [FRAME_LEN];
    t_frame_result               expected_results [$];

    function automatic logic [flfr_pkg::BYTE_W-1:0] accumulate(
            input logic [flfr_pkg::BYTE_W-1:0] acc,
            input logic [flfr_pkg::BYTE_W-1:0] b);
        if (regs.check_mode == flfr_pkg::CHECK_XOR) begin
            return acc ^ b;
        end
        return acc + b;
    endfunction

    task automatic judge_frame();
        t_frame_result r;
        if (frame_bytes[0] != regs.own_address && frame_bytes[0] != regs.bcast_addr) begin
            return;
        end
        if (frame_bytes[FRAME_LEN-1] != check_acc) begin
            r.payload = '0;
            r.status = flfr_pkg::STATUS_CHECK_ERROR;
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        for (int i = PAYLOAD_START; i <= FRAME_LEN - 2; i++) begin
            r.payload = frame_bytes[i];
            r.status = flfr_pkg::STATUS_PAYLOAD;
            r.last = (i == FRAME_LEN - 2);
            expected_results.push_back(r);
        end
    endtask

    task automatic take_byte(input logic [flfr_pkg::BYTE_W-1:0] b);
        if (!in_frame) begin
            if (b == regs.start_byte) begin
                in_frame = 1'b1;
                frame_pos = 0;
                check_acc = '0;
            end
            return;
        end
        frame_bytes[frame_pos] = b;
        if (frame_pos < FRAME_LEN - 1) begin
            check_acc = accumulate(check_acc, b);
        end
        frame_pos++;
        if (frame_pos == FRAME_LEN) begin
            in_frame = 1'b0;
            frame_pos = 0;
            judge_frame();
            check_acc = '0;
        end
    endtask

    task automatic compare_result();
        t_frame_result got;
        t_frame_result want;
        got.payload = i_m_tdata;
        got.status = i_m_tuser;
        got.last = i_m_tlast;
        if (expected_results.size() == 0) begin
            if (o_mismatches < 10) begin
                $display("%0t: unexpected result data %02h status %0d last %0d",
                         $realtime, got.payload, got.status, got.last);
            end
            o_mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (got.payload !== want.payload || got.status !== want.status
                || got.last !== want.last) begin
            if (o_mismatches < 10) begin
                $display({"%0t: result mismatch, expected data %02h status %0d last %0d,",
                          " got data %02h status %0d last %0d"},
                         $realtime, want.payload, want.status, want.last,
                         got.payload, got.status, got.last);
            end
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.start_byte = 8'h00;
            regs.own_address = 8'h00;
            regs.bcast_addr = 8'hFF;
            regs.check_mode = flfr_pkg::CHECK_SUM;
            in_frame = 1'b0;
            frame_pos = 0;
            check_acc = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    flfr_pkg::CFG_START_BYTE:  regs.start_byte = i_cfg_data;
                    flfr_pkg::CFG_OWN_ADDRESS: regs.own_address = i_cfg_data;
                    flfr_pkg::CFG_BCAST_ADDR:  regs.bcast_addr = i_cfg_data;
                    flfr_pkg::CFG_CHECK_MODE:  regs.check_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                compare_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                take_byte(i_s_tdata);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: test/tb_fixed_length_frame_receiver.sv
`timescale 1ns / 1ps
// testbench top for the fixed length frame receiver: frame stimulus, random stalls, verdict
module tb_fixed_length_frame_receiver;

    localparam int FRAME_LEN = 16;
    localparam int PAYLOAD_START = 1;
    // accepted bytes after which the random part stops (hunting noise not counted)
    localparam int ITEM_TARGET = 410;
    // idle time that covers the read-out of a good frame, plus margin
    localparam int DRAIN_CYCLES = 2 * FRAME_LEN + 8;
    localparam int FRAMES_PER_PHASE = 5;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [flfr_pkg::CFG_IDX_W-1:0] cfg_idx = flfr_pkg::CFG_START_BYTE;
    logic [flfr_pkg::BYTE_W-1:0]    cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [flfr_pkg::BYTE_W-1:0]    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [flfr_pkg::BYTE_W-1:0]    m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    int                             mismatches;
    int                             pending;

    // register settings as last written, used to build well-formed frames
    logic [flfr_pkg::BYTE_W-1:0]    cur_start = 8'h00;
    logic [flfr_pkg::BYTE_W-1:0]    cur_own = 8'h00;
    logic [flfr_pkg::BYTE_W-1:0]    cur_bc = 8'hFF;
    logic                           cur_mode = flfr_pkg::CHECK_SUM;

    logic [flfr_pkg::BYTE_W-1:0]    frame_buf [FRAME_LEN];
    int                             frame_items = 0;
    int                             frames_sent = 0;
    int                             phase = 0;
    int                             kind;
    int                             pattern;
    bit                             burst = 1'b0;

    // result sink pacing state
    int                             sink_hold = 0;
    int                             sink_sel;
    logic                           sink_level = 1'b0;

    always #6 i_clk = ~i_clk;

    fixed_length_frame_receiver #(
        .FRAME_LEN(FRAME_LEN),
        .PAYLOAD_START(PAYLOAD_START)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .o_m_tlast(m_tlast)
    );

    flfr_result_checker #(
        .FRAME_LEN(FRAME_LEN),
        .PAYLOAD_START(PAYLOAD_START)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_m_tlast(m_tlast),
        .o_mismatches(mismatches),
        .o_pending(pending)
    );

    // result sink: long ready runs, short stalls, now and then a long stall
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
        end else begin
            sink_sel = $urandom_range(0, 19);
            if (sink_sel < 10) begin
                sink_level = 1'b1;
                sink_hold = $urandom_range(1, 40);
            end else if (sink_sel < 17) begin
                sink_level = 1'b0;
                sink_hold = $urandom_range(0, 3);
            end else begin
                sink_level = 1'b0;
                sink_hold = $urandom_range(10, 60);
            end
        end
        m_tready <= sink_level;
    end

    // one byte request; valid stays high when no gap follows
    task automatic send_byte(input logic [flfr_pkg::BYTE_W-1:0] b);
        int sel;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge i_clk); while (!s_tready);
        sel = $urandom_range(0, 19);
        if (burst || sel < 11) begin
            gap = 0;
        end else if (sel < 18) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // bytes the block drops while hunting, never the start byte
    task automatic send_noise(input int count);
        logic [flfr_pkg::BYTE_W-1:0] n;
        repeat (count) begin
            do n = 8'($urandom); while (n == cur_start);
            send_byte(n);
        end
    endtask

    // address byte plus data; pattern 0 random, 1 zeros, 2 ones, 3 start bytes mixed in
    task automatic fill_frame(input logic [flfr_pkg::BYTE_W-1:0] addr, input int pat);
        frame_buf[0] = addr;
        for (int i = 1; i <= FRAME_LEN - 2; i++) begin
            case (pat)
                1:       frame_buf[i] = 8'h00;
                2:       frame_buf[i] = 8'hFF;
                3:       frame_buf[i] = ($urandom_range(0, 2) == 0) ? cur_start : 8'($urandom);
                default: frame_buf[i] = 8'($urandom);
            endcase
        end
    endtask

    // start byte, then frame_buf with a correct or a corrupted check byte
    task automatic send_frame(input bit good_check);
        logic [flfr_pkg::BYTE_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            acc = (cur_mode == flfr_pkg::CHECK_XOR) ? (acc ^ frame_buf[i])
                                                    : (acc + frame_buf[i]);
        end
        frame_buf[FRAME_LEN-1] = good_check ? acc : (acc ^ 8'($urandom_range(1, 255)));
        send_byte(cur_start);
        for (int i = 0; i < FRAME_LEN; i++) begin
            send_byte(frame_buf[i]);
        end
        frame_items += FRAME_LEN + 1;
    endtask

    // hold off requests until every expected result is back; sampled mid-cycle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // all four registers, written back to back once the block is quiet
    task automatic write_cfg(input logic [flfr_pkg::BYTE_W-1:0] st,
                             input logic [flfr_pkg::BYTE_W-1:0] own,
                             input logic [flfr_pkg::BYTE_W-1:0] bc, input logic mode);
        wait_drained();
        // a dropped frame gives no result, so allow for a full read-out anyway
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= flfr_pkg::CFG_START_BYTE;
        cfg_data <= st;
        @(posedge i_clk);
        cfg_idx <= flfr_pkg::CFG_OWN_ADDRESS;
        cfg_data <= own;
        @(posedge i_clk);
        cfg_idx <= flfr_pkg::CFG_BCAST_ADDR;
        cfg_data <= bc;
        @(posedge i_clk);
        // upper bits are junk, only bit 0 selects the check kind
        cfg_idx <= flfr_pkg::CFG_CHECK_MODE;
        cfg_data <= {7'($urandom), mode};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_start = st;
        cur_own = own;
        cur_bc = bc;
        cur_mode = mode;
    endtask

    // register settings per phase: extremes first, then random
    task automatic next_phase_cfg();
        logic [flfr_pkg::BYTE_W-1:0] a;
        case (phase)
            0: write_cfg(8'hFF, 8'h00, 8'hFF, flfr_pkg::CHECK_XOR);
            1: write_cfg(8'h00, 8'hFF, 8'h00, flfr_pkg::CHECK_SUM);
            2: begin
                // own and broadcast address equal
                a = 8'($urandom);
                write_cfg(8'($urandom), a, a, flfr_pkg::CHECK_XOR);
            end
            default: write_cfg(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        endcase
        phase++;
    endtask

    task automatic pick_foreign(output logic [flfr_pkg::BYTE_W-1:0] a);
        do a = 8'($urandom); while (a == cur_own || a == cur_bc);
    endtask

    initial begin
        logic [flfr_pkg::BYTE_W-1:0] addr;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default registers, a dropped byte while hunting, then a frame to
        // the own address with extreme data and the start byte stored as data
        send_noise(1);
        fill_frame(cur_own, 0);
        frame_buf[1] = 8'h00;
        frame_buf[2] = 8'hFF;
        frame_buf[3] = cur_start;
        frame_buf[4] = 8'h80;
        frame_buf[5] = 8'h01;
        frame_buf[6] = 8'h7F;
        send_frame(1'b1);
        // hold the sender until the whole payload has come out
        wait_drained();

        // random frames, mostly well formed; registers change every few frames
        while (frame_items < ITEM_TARGET) begin
            if (frames_sent % FRAMES_PER_PHASE == 0) begin
                next_phase_cfg();
            end
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                send_noise($urandom_range(1, 3));
            end
            kind = $urandom_range(0, 9);
            pattern = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
            case (kind)
                0, 1, 2, 3: begin
                    fill_frame(cur_own, pattern);
                    send_frame(1'b1);
                end
                4, 5: begin
                    fill_frame(cur_bc, pattern);
                    send_frame(1'b1);
                end
                6, 7: begin
                    // bad check byte, to either accepted address
                    fill_frame(($urandom_range(0, 1) == 0) ? cur_own : cur_bc, pattern);
                    send_frame(1'b0);
                end
                8: begin
                    // foreign address, dropped whatever the check byte
                    pick_foreign(addr);
                    fill_frame(addr, pattern);
                    send_frame(1'($urandom));
                end
                default: begin
                    // start byte inside the frame is just data
                    fill_frame(cur_own, 3);
                    send_frame(1'b1);
                end
            endcase
            frames_sent++;
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit, many times the slowest legal run
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
